// File: rtl/icr_pkg.sv
// ----------------------------------------------------------------------------
// icr_pkg
// shared constants, codes and types of the inode cache with reference counts
// ----------------------------------------------------------------------------
package icr_pkg;

  localparam int TABLE_SLOTS  = 64;
  localparam int SECTOR_BYTES = 512;
  localparam int INODE_BYTES  = 32;

  localparam int INODES_PER_SECTOR =
      (SECTOR_BYTES / INODE_BYTES == 0) ? 1 : SECTOR_BYTES / INODE_BYTES;
  localparam int LEAD_SECTORS = 1 + 1;

  localparam int SLOT_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;

  localparam int REQ_W    = 2;
  localparam int DEV_W    = 16;
  localparam int INO_W    = 12;
  localparam int IDX_W    = 6;
  localparam int STAT_W   = 3;
  localparam int SECTOR_W = 32;
  localparam int OFFS_W   = 9;
  localparam int REFS_W   = 8;

  localparam int IMS_W      = 8;
  localparam int SMS_W      = 21;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 21;

  localparam logic [REFS_W-1:0] REF_MAX = '1;

  typedef enum logic [REQ_W-1:0] {
    REQ_GET     = 2'd0,
    REQ_RELEASE = 2'd1,
    REQ_LOCATE  = 2'd2,
    REQ_NONE    = 2'd3
  } req_e_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_DONE     = 3'd0,
    STAT_ALLOC    = 3'd1,
    STAT_RESERVED = 3'd2,
    STAT_FULL     = 3'd3,
    STAT_UNUSED   = 3'd4,
    STAT_SAT      = 3'd5
  } status_e_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INODE_MAP  = 1'b0,
    CFG_SECTOR_MAP = 1'b1
  } cfg_reg_e_t;

  typedef struct packed {
    logic [DEV_W-1:0]  dev;
    logic [INO_W-1:0]  ino;
    logic [REFS_W-1:0] refs;
  } slot_ent_t;

endpackage

// File: rtl/icr_in_if.sv
// ----------------------------------------------------------------------------
// icr_in_if
// request channel: valid/ready with request type, device, inode and slot
// ----------------------------------------------------------------------------
interface icr_in_if;
  import icr_pkg::*;

  logic             valid;
  logic             ready;
  logic [REQ_W-1:0] req_type;
  logic [DEV_W-1:0] device;
  logic [INO_W-1:0] inode_number;
  logic [IDX_W-1:0] slot_index;

  modport source (output valid, req_type, device, inode_number, slot_index, input ready);
  modport sink (input valid, req_type, device, inode_number, slot_index, output ready);
endinterface

// File: rtl/icr_out_if.sv
// ----------------------------------------------------------------------------
// icr_out_if
// result channel: valid/ready with status, slot, disk location and count
// ----------------------------------------------------------------------------
interface icr_out_if;
  import icr_pkg::*;

  logic                valid;
  logic                ready;
  logic [STAT_W-1:0]   status;
  logic [IDX_W-1:0]    slot;
  logic [SECTOR_W-1:0] sector_number;
  logic [OFFS_W-1:0]   byte_offset;
  logic [REFS_W-1:0]   ref_count;

  modport source (output valid, status, slot, sector_number, byte_offset, ref_count,
                  input ready);
  modport sink (input valid, status, slot, sector_number, byte_offset, ref_count,
                output ready);
endinterface

// File: rtl/icr_cfg_if.sv
// ----------------------------------------------------------------------------
// icr_cfg_if
// configuration write channel: valid/ready with register index and data
// ----------------------------------------------------------------------------
interface icr_cfg_if;
  import icr_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/inode_cache_refcount.sv
// ----------------------------------------------------------------------------
// inode_cache_refcount
// table of inode slots with reference counts, kept in one synchronous memory
// ----------------------------------------------------------------------------
// channel  port     direction  transfer carries
// request  in_req   sink       req_type, device, inode_number, slot_index
// result   out_rsp  source     status, slot, sector_number, byte_offset, ref_count
// config   cfg_wr   sink       index, data (always ready)
//
// get: one memory read per slot, the scan reading the slots in order after
// accept and before the finishing state; a hit ends the scan early. release
// and locate read the named slot; a reserved inode goes straight to finishing.
// one request at a time; the result waits in an output register, and a
// stalled result holds the finishing cycle and its memory write.
// reset clears slot valid bits and loads both map sizes with 1.
// ----------------------------------------------------------------------------
module inode_cache_refcount (
  input  logic clk,
  input  logic rst_n,
  icr_in_if.sink    in_req,
  icr_out_if.source out_rsp,
  icr_cfg_if.sink   cfg_wr
);
  import icr_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_SLOT = 4'b0100,
    ST_FIN  = 4'b1000
  } state_e_t;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SLOTS - 1);

  state_e_t state_r;

  logic [IMS_W-1:0] ims_r;
  logic [SMS_W-1:0] sms_r;

  // slot storage
  slot_ent_t        mem [TABLE_SLOTS];
  logic [TABLE_SLOTS-1:0] vld_r;
  slot_ent_t        ent_q;
  logic             vld_q;
  logic [SLOT_W-1:0] rd_addr;
  logic             wr_en;

  // request capture
  req_e_t           op_r;
  logic [DEV_W-1:0] dev_r;
  logic [INO_W-1:0] num_r;
  logic [IDX_W-1:0] idx_r;

  // scan
  logic [SLOT_W-1:0] cur_r;
  logic              free_found_r;
  logic [SLOT_W-1:0] free_slot_r;

  // finishing stage
  status_e_t         fin_status_r;
  logic [SLOT_W-1:0] fin_addr_r;
  logic [REFS_W-1:0] fin_refs_r;
  logic              fin_loc_r;
  logic [INO_W-1:0]  fin_ino_r;
  logic              fin_wr_r;
  slot_ent_t         fin_ent_r;

  // output register
  logic                out_valid_r;
  status_e_t           out_status_r;
  logic [IDX_W-1:0]    out_slot_r;
  logic [SECTOR_W-1:0] out_sector_r;
  logic [OFFS_W-1:0]   out_offs_r;
  logic [REFS_W-1:0]   out_refs_r;

  logic                in_fire;
  logic                out_free;
  logic                used;
  logic                hit;
  logic [INO_W-1:0]    loc_k;
  logic [SECTOR_W-1:0] loc_sector;
  logic [OFFS_W-1:0]   loc_offs;
  logic [IDX_W-1:0]    rsp_slot;

  assign in_req.ready = (state_r == ST_IDLE);
  assign cfg_wr.ready = 1'b1;
  assign in_fire      = in_req.valid && in_req.ready;
  assign out_free     = !out_valid_r || out_rsp.ready;

  assign out_rsp.valid         = out_valid_r;
  assign out_rsp.status        = out_status_r;
  assign out_rsp.slot          = out_slot_r;
  assign out_rsp.sector_number = out_sector_r;
  assign out_rsp.byte_offset   = out_offs_r;
  assign out_rsp.ref_count     = out_refs_r;

  assign used = vld_q && (ent_q.refs != '0);
  assign hit  = used && (ent_q.dev == dev_r) && (ent_q.ino == num_r);

  always_comb begin
    unique case (state_r)
      ST_IDLE: begin
        rd_addr = (in_req.req_type == REQ_GET) ? '0 : SLOT_W'(in_req.slot_index);
      end
      ST_SCAN: begin
        rd_addr = SLOT_W'(cur_r + 1'b1);
      end
      default: begin
        rd_addr = '0;
      end
    endcase
  end

  // disk location of the inode
  assign loc_k      = INO_W'(fin_ino_r - 1'b1);
  assign loc_sector = SECTOR_W'(LEAD_SECTORS) + SECTOR_W'(ims_r) + SECTOR_W'(sms_r)
                      + SECTOR_W'(loc_k / INODES_PER_SECTOR);
  assign loc_offs   = OFFS_W'((loc_k % INODES_PER_SECTOR) * INODE_BYTES);
  assign rsp_slot   = (fin_status_r == STAT_UNUSED) ? idx_r : IDX_W'(fin_addr_r);

  assign wr_en = (state_r == ST_FIN) && out_free && fin_wr_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[fin_addr_r] <= fin_ent_r;
    end
    ent_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      vld_r        <= '0;
      vld_q        <= 1'b0;
      out_valid_r  <= 1'b0;
      ims_r        <= IMS_W'(1);
      sms_r        <= SMS_W'(1);
      free_found_r <= 1'b0;
    end else begin
      vld_q <= vld_r[rd_addr];

      if (cfg_wr.valid) begin
        unique case (cfg_wr.index)
          CFG_INODE_MAP:  ims_r <= cfg_wr.data[IMS_W-1:0];
          CFG_SECTOR_MAP: sms_r <= cfg_wr.data[SMS_W-1:0];
          default: ;
        endcase
      end

      if (out_valid_r && out_rsp.ready && state_r != ST_FIN) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            op_r         <= req_e_t'(in_req.req_type);
            dev_r        <= in_req.device;
            num_r        <= in_req.inode_number;
            idx_r        <= in_req.slot_index;
            cur_r        <= '0;
            free_found_r <= 1'b0;
            fin_wr_r     <= 1'b0;
            fin_loc_r    <= 1'b0;
            fin_refs_r   <= '0;
            fin_addr_r   <= (in_req.req_type == REQ_GET) ? '0
                                                         : SLOT_W'(in_req.slot_index);
            priority if (in_req.req_type == REQ_NONE) begin
              state_r <= ST_IDLE;
            end else if (in_req.req_type == REQ_GET) begin
              if (in_req.inode_number == '0) begin
                fin_status_r <= STAT_RESERVED;
                state_r      <= ST_FIN;
              end else begin
                state_r <= ST_SCAN;
              end
            end else if (int'(in_req.slot_index) >= TABLE_SLOTS) begin
              fin_status_r <= STAT_UNUSED;
              state_r      <= ST_FIN;
            end else begin
              state_r <= ST_SLOT;
            end
          end
        end

        ST_SCAN: begin
          if (hit) begin
            fin_addr_r <= cur_r;
            fin_loc_r  <= 1'b1;
            fin_ino_r  <= num_r;
            fin_ent_r  <= '{dev: dev_r, ino: num_r,
                            refs: (ent_q.refs == REF_MAX) ? REF_MAX
                                                          : REFS_W'(ent_q.refs + 1'b1)};
            fin_wr_r   <= (ent_q.refs != REF_MAX);
            fin_refs_r <= (ent_q.refs == REF_MAX) ? REF_MAX : REFS_W'(ent_q.refs + 1'b1);
            fin_status_r <= (ent_q.refs == REF_MAX) ? STAT_SAT : STAT_DONE;
            state_r    <= ST_FIN;
          end else if (cur_r == LAST_SLOT) begin
            if (free_found_r || !used) begin
              fin_addr_r   <= free_found_r ? free_slot_r : cur_r;
              fin_loc_r    <= 1'b1;
              fin_ino_r    <= num_r;
              fin_ent_r    <= '{dev: dev_r, ino: num_r, refs: REFS_W'(1)};
              fin_wr_r     <= 1'b1;
              fin_refs_r   <= REFS_W'(1);
              fin_status_r <= STAT_ALLOC;
            end else begin
              fin_addr_r   <= '0;
              fin_status_r <= STAT_FULL;
            end
            state_r <= ST_FIN;
          end else begin
            if (!used && !free_found_r) begin
              free_found_r <= 1'b1;
              free_slot_r  <= cur_r;
            end
            cur_r <= SLOT_W'(cur_r + 1'b1);
          end
        end

        ST_SLOT: begin
          if (!used) begin
            fin_status_r <= STAT_UNUSED;
          end else if (op_r == REQ_RELEASE) begin
            fin_status_r <= STAT_DONE;
            fin_refs_r   <= REFS_W'(ent_q.refs - 1'b1);
            fin_ent_r    <= '{dev: ent_q.dev, ino: ent_q.ino,
                              refs: REFS_W'(ent_q.refs - 1'b1)};
            fin_wr_r     <= 1'b1;
          end else begin
            fin_status_r <= STAT_DONE;
            fin_refs_r   <= ent_q.refs;
            fin_loc_r    <= 1'b1;
            fin_ino_r    <= ent_q.ino;
          end
          state_r <= ST_FIN;
        end

        ST_FIN: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_status_r <= fin_status_r;
            out_slot_r   <= rsp_slot;
            out_refs_r   <= fin_refs_r;
            out_sector_r <= fin_loc_r ? loc_sector : '0;
            out_offs_r   <= fin_loc_r ? loc_offs : '0;
            if (fin_wr_r) begin
              vld_r[fin_addr_r] <= 1'b1;
            end
            state_r <= ST_IDLE;
          end
        end

        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // a written slot reads as valid from then on
  a_wr_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> vld_r[$past(fin_addr_r)])
    else $error("written slot not marked valid");

  // a stalled result keeps the finishing cycle and its write pending
  a_fin_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && out_valid_r && !out_rsp.ready) |=> state_r == ST_FIN)
    else $error("finishing cycle left while result stalled");

  // a get of a real inode always starts a scan
  a_get_scans: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_req.req_type == REQ_GET && in_req.inode_number != '0)
      |=> (state_r == ST_SCAN && cur_r == '0))
    else $error("get did not start a scan at slot zero");

  // an allocated slot is written with a count of one
  a_wr_nonzero_on_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && fin_status_r == STAT_ALLOC) |-> fin_ent_r.refs == REFS_W'(1))
    else $error("allocated slot written without count one");

  // no request taken while a result waits to be produced
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN || state_r == ST_SLOT) |-> !in_req.ready)
    else $error("request accepted during lookup");

endmodule

// File: sim/tb_inode_cache_refcount.sv
// ----------------------------------------------------------------------------
// tb_inode_cache_refcount
// self-checking bench for the inode slot table with reference counts.
// requests go in through the request channel. a predictor of the slot table
// and the map sizes works out each reply, and a monitor compares every reply
// transfer field by field. the run covers directed cases, a table filled to
// the last slot, a count driven into saturation, and three phases of random
// traffic, mostly over a set of 48 inodes, each phase with its own map sizes and stalls
// ----------------------------------------------------------------------------
module tb_inode_cache_refcount;
  timeunit 1ns;
  timeprecision 1ps;
  import icr_pkg::*;

  localparam int MAP_SETTLE = 80;
  localparam int IDLE_LIMIT = 4000;
  localparam int REPORT_MAX = 10;
  localparam int POOL_KEYS  = 48;

  typedef struct packed {
    req_e_t            kind;
    logic [DEV_W-1:0]  dev;
    logic [INO_W-1:0]  ino;
    logic [IDX_W-1:0]  idx;
  } fs_req_t;

  typedef struct packed {
    status_e_t           status;
    logic [IDX_W-1:0]    slot;
    logic [SECTOR_W-1:0] sector;
    logic [OFFS_W-1:0]   offset;
    logic [REFS_W-1:0]   refs;
  } fs_reply_t;

  logic clk;
  logic rst_n;

  icr_in_if  in_ch ();
  icr_out_if out_ch ();
  icr_cfg_if cfg_ch ();

  inode_cache_refcount dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (in_ch),
    .out_rsp(out_ch),
    .cfg_wr (cfg_ch)
  );

  int src_idle_pct   = 17;
  int sink_stall_pct = 64;
  int mismatch_cnt   = 0;
  int idle_cycles    = 0;

  fs_reply_t expected_replies[$];
  fs_reply_t last_reply;

  logic [DEV_W-1:0]  cached_dev  [TABLE_SLOTS];
  logic [INO_W-1:0]  cached_ino  [TABLE_SLOTS];
  logic [REFS_W-1:0] cached_refs [TABLE_SLOTS];
  logic [IMS_W-1:0]  inode_map_len;
  logic [SMS_W-1:0]  sector_map_len;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic void disk_place(input logic [INO_W-1:0] n,
                                     output logic [SECTOR_W-1:0] sec,
                                     output logic [OFFS_W-1:0] off);
    logic [INO_W-1:0] k;
    k   = n - 1'b1;
    sec = SECTOR_W'(LEAD_SECTORS + inode_map_len + sector_map_len
                    + k / INODES_PER_SECTOR);
    off = OFFS_W'((k % INODES_PER_SECTOR) * INODE_BYTES);
  endfunction

  function automatic bit serve_request(input fs_req_t r, output fs_reply_t y);
    int hit_at;
    int free_at;
    y = '0;
    if (r.kind == REQ_NONE) return 1'b0;
    if (r.kind == REQ_GET) begin
      if (r.ino == '0) begin
        y.status = STAT_RESERVED;
      end else begin
        hit_at  = -1;
        free_at = -1;
        for (int i = 0; i < TABLE_SLOTS; i++) begin
          if (cached_refs[i] != '0) begin
            if (cached_dev[i] == r.dev && cached_ino[i] == r.ino) begin
              hit_at = i;
              break;
            end
          end else if (free_at < 0) begin
            free_at = i;
          end
        end
        if (hit_at >= 0) begin
          if (cached_refs[hit_at] == REF_MAX) begin
            y.status = STAT_SAT;
          end else begin
            cached_refs[hit_at]++;
            y.status = STAT_DONE;
          end
          y.slot = IDX_W'(hit_at);
          y.refs = cached_refs[hit_at];
          disk_place(r.ino, y.sector, y.offset);
        end else if (free_at < 0) begin
          y.status = STAT_FULL;
        end else begin
          cached_dev[free_at]  = r.dev;
          cached_ino[free_at]  = r.ino;
          cached_refs[free_at] = REFS_W'(1);
          y.status = STAT_ALLOC;
          y.slot   = IDX_W'(free_at);
          y.refs   = REFS_W'(1);
          disk_place(r.ino, y.sector, y.offset);
        end
      end
    end else begin
      y.slot = r.idx;
      if (int'(r.idx) >= TABLE_SLOTS || cached_refs[r.idx] == '0) begin
        y.status = STAT_UNUSED;
      end else if (r.kind == REQ_RELEASE) begin
        cached_refs[r.idx]--;
        y.status = STAT_DONE;
        y.refs   = cached_refs[r.idx];
      end else begin
        y.status = STAT_DONE;
        y.refs   = cached_refs[r.idx];
        disk_place(cached_ino[r.idx], y.sector, y.offset);
      end
    end
    return 1'b1;
  endfunction

  function automatic fs_req_t make_req(input req_e_t k, input logic [DEV_W-1:0] d,
                                       input logic [INO_W-1:0] n,
                                       input logic [IDX_W-1:0] s);
    fs_req_t r;
    r.kind = k;
    r.dev  = d;
    r.ino  = n;
    r.idx  = s;
    return r;
  endfunction

  task automatic issue_request(input fs_req_t r);
    fs_reply_t y;
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.req_type     <= r.kind;
    in_ch.device       <= r.dev;
    in_ch.inode_number <= r.ino;
    in_ch.slot_index   <= r.idx;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (serve_request(r, y)) expected_replies.push_back(y);
    last_reply = y;
  endtask

  task automatic drain_replies();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_replies.size() != 0);
    repeat (MAP_SETTLE) @(posedge clk);
  endtask

  task automatic load_map_sizes(input logic [IMS_W-1:0] ims, input logic [SMS_W-1:0] sms);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= CFG_INODE_MAP;
    cfg_ch.data  <= CFG_DATA_W'(ims);
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    inode_map_len = ims;
    cfg_ch.index <= CFG_SECTOR_MAP;
    cfg_ch.data  <= CFG_DATA_W'(sms);
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    sector_map_len = sms;
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic test_directed();
    issue_request(make_req(REQ_GET, 16'h0000, 12'h000, 6'h00));
    issue_request(make_req(REQ_GET, 16'hFFFF, 12'h000, 6'h3F));
    issue_request(make_req(REQ_GET, 16'h0000, 12'h001, 6'h00));
    issue_request(make_req(REQ_GET, 16'hFFFF, 12'hFFF, 6'h00));
    issue_request(make_req(REQ_GET, 16'h0000, 12'h001, 6'h00));
    issue_request(make_req(REQ_GET, 16'hFFFF, 12'h001, 6'h00));
    issue_request(make_req(REQ_GET, 16'h1234, 12'd16, 6'h00));
    issue_request(make_req(REQ_GET, 16'h1234, 12'd17, 6'h00));
    issue_request(make_req(REQ_LOCATE, 16'h0000, 12'h000, 6'd1));
    issue_request(make_req(REQ_LOCATE, 16'hFFFF, 12'hFFF, 6'h3F));
    issue_request(make_req(REQ_RELEASE, 16'h0000, 12'h000, 6'h3F));
    issue_request(make_req(REQ_RELEASE, 16'h0000, 12'h000, 6'd2));
    issue_request(make_req(REQ_RELEASE, 16'h0000, 12'h000, 6'd2));
    issue_request(make_req(REQ_LOCATE, 16'h0000, 12'h000, 6'd2));
    issue_request(make_req(REQ_NONE, 16'hFFFF, 12'hFFF, 6'h3F));
    issue_request(make_req(REQ_GET, 16'h8000, 12'h800, 6'h00));
    issue_request(make_req(REQ_NONE, 16'h0000, 12'h000, 6'h00));
    issue_request(make_req(REQ_LOCATE, 16'h0000, 12'h000, 6'd0));
    issue_request(make_req(REQ_RELEASE, 16'h0000, 12'h000, 6'd0));
    issue_request(make_req(REQ_RELEASE, 16'h0000, 12'h000, 6'd0));
    issue_request(make_req(REQ_GET, 16'h0000, 12'h001, 6'h00));
    drain_replies();
  endtask

  task automatic test_table_full();
    int  n;
    bit  room;
    load_map_sizes(8'd255, 21'd1048577);
    n    = 1;
    room = 1'b1;
    while (room) begin
      issue_request(make_req(REQ_GET, 16'hC3A5, INO_W'(n), IDX_W'($urandom)));
      n++;
      room = 1'b0;
      foreach (cached_refs[i]) if (cached_refs[i] == '0) room = 1'b1;
    end
    issue_request(make_req(REQ_GET, 16'hC3A5, INO_W'(n), 6'h00));
    issue_request(make_req(REQ_GET, 16'h5A3C, 12'hFFF, 6'h3F));
    issue_request(make_req(REQ_GET, 16'hC3A5, 12'd1, 6'h00));
    issue_request(make_req(REQ_GET, 16'hC3A5, 12'd0, 6'h00));
    issue_request(make_req(REQ_LOCATE, 16'h0000, 12'h000, 6'h3F));
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      while (cached_refs[i] != '0)
        issue_request(make_req(REQ_RELEASE, 16'h0000, 12'h000, IDX_W'(i)));
    end
    drain_replies();
  endtask

  task automatic test_saturation();
    logic [DEV_W-1:0] d;
    logic [INO_W-1:0] n;
    logic [IDX_W-1:0] s;
    d = DEV_W'($urandom);
    n = INO_W'($urandom_range(1, 4095));
    load_map_sizes(IMS_W'($urandom_range(1, 255)), SMS_W'($urandom_range(1, 1048577)));
    repeat (int'(REF_MAX) + 2) issue_request(make_req(REQ_GET, d, n, 6'h00));
    s = last_reply.slot;
    issue_request(make_req(REQ_LOCATE, 16'h0000, 12'h000, s));
    issue_request(make_req(REQ_RELEASE, 16'h0000, 12'h000, s));
    issue_request(make_req(REQ_GET, d, n, 6'h00));
    issue_request(make_req(REQ_GET, d, n, 6'h00));
    drain_replies();
  endtask

  task automatic test_random_traffic(input int count, input logic [IMS_W-1:0] ims,
                                     input logic [SMS_W-1:0] sms);
    logic [DEV_W-1:0] pool_dev [POOL_KEYS];
    logic [INO_W-1:0] pool_ino [POOL_KEYS];
    logic [IDX_W-1:0] target;
    logic [INO_W-1:0] n;
    int               live [$];
    int               sent;
    int               roll;
    int               pick;
    load_map_sizes(ims, sms);
    foreach (pool_dev[k]) begin
      pool_dev[k] = DEV_W'($urandom);
      pool_ino[k] = INO_W'($urandom_range(1, 4095));
    end
    sent = 0;
    while (sent < count) begin
      roll = $urandom_range(99);
      pick = $urandom_range(POOL_KEYS - 1);
      live.delete();
      foreach (cached_refs[k]) if (cached_refs[k] != '0) live.push_back(k);
      if (live.size() != 0) target = IDX_W'(live[$urandom_range(live.size() - 1)]);
      else target = IDX_W'($urandom);
      if (roll < 45) begin
        issue_request(make_req(REQ_GET, pool_dev[pick], pool_ino[pick], IDX_W'($urandom)));
      end else if (roll < 65) begin
        issue_request(make_req(REQ_RELEASE, DEV_W'($urandom), INO_W'($urandom), target));
      end else if (roll < 80) begin
        issue_request(make_req(REQ_LOCATE, DEV_W'($urandom), INO_W'($urandom), target));
      end else if (roll < 90) begin
        n = ($urandom_range(9) == 0) ? '0 : INO_W'($urandom);
        issue_request(make_req(REQ_GET, DEV_W'($urandom), n, IDX_W'($urandom)));
      end else if (roll < 96) begin
        issue_request(make_req($urandom_range(1) ? REQ_RELEASE : REQ_LOCATE,
                               DEV_W'($urandom), INO_W'($urandom), IDX_W'($urandom)));
      end else begin
        issue_request(make_req(REQ_NONE, DEV_W'($urandom), INO_W'($urandom),
                               IDX_W'($urandom)));
        sent--;
      end
      sent++;
    end
    drain_replies();
  endtask

  // reply monitor, receiver stalls and the no-progress counter
  always @(posedge clk) begin
    fs_reply_t want;
    out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_replies.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= REPORT_MAX)
          $display("unexpected reply at %0t: status %0d slot %0d sector %0d offset %0d refs %0d",
                   $time, out_ch.status, out_ch.slot, out_ch.sector_number,
                   out_ch.byte_offset, out_ch.ref_count);
      end else begin
        want = expected_replies.pop_front();
        if (out_ch.status !== want.status || out_ch.slot !== want.slot ||
            out_ch.sector_number !== want.sector || out_ch.byte_offset !== want.offset ||
            out_ch.ref_count !== want.refs) begin
          mismatch_cnt++;
          if (mismatch_cnt <= REPORT_MAX)
            $display("reply mismatch at %0t: expected status %0d slot %0d sector %0d",
                     $time, want.status, want.slot, want.sector,
                     " offset %0d refs %0d, got status %0d slot %0d sector %0d",
                     want.offset, want.refs, out_ch.status, out_ch.slot,
                     out_ch.sector_number, " offset %0d refs %0d",
                     out_ch.byte_offset, out_ch.ref_count);
        end
      end
    end
  end

  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.req_type      <= REQ_GET;
    in_ch.device        <= '0;
    in_ch.inode_number  <= '0;
    in_ch.slot_index    <= '0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.index        <= CFG_INODE_MAP;
    cfg_ch.data         <= '0;
    inode_map_len  = IMS_W'(1);
    sector_map_len = SMS_W'(1);
    foreach (cached_refs[i]) begin
      cached_refs[i] = '0;
      cached_dev[i]  = '0;
      cached_ino[i]  = '0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    src_idle_pct   = 17;
    sink_stall_pct = 64;
    test_directed();
    test_table_full();
    test_saturation();
    test_random_traffic(250, 8'd1, 21'd1048577);

    src_idle_pct   = 64;
    sink_stall_pct = 17;
    test_random_traffic(250, 8'd255, 21'd1);

    src_idle_pct   = 0;
    sink_stall_pct = 0;
    test_random_traffic(250, IMS_W'($urandom_range(1, 255)), 21'h1FFFFF);

    if (mismatch_cnt == 0 && expected_replies.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

// File: filelist.f
rtl/icr_pkg.sv
rtl/icr_in_if.sv
rtl/icr_out_if.sv
rtl/icr_cfg_if.sv
rtl/inode_cache_refcount.sv
sim/tb_inode_cache_refcount.sv
